// File: rtl/core/rpp_pkg.sv
package rpp_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam logic [31:0] STEP_LENGTH_RST = 32'h0001_0000;

	typedef enum logic [2:0] {
		FN_TICK    = 3'd0,
		FN_ABSORB  = 3'd1,
		FN_SCATTER = 3'd2,
		FN_FISSION = 3'd3,
		FN_LOADPOS = 3'd4,
		FN_LOADMOM = 3'd5,
		FN_MOVETO  = 3'd6,
		FN_NOP     = 3'd7
	} func_t;

	localparam logic REG_REST_MASS   = 1'b0;
	localparam logic REG_STEP_LENGTH = 1'b1;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

// File: rtl/core/relativistic_particle_push.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | func, value_x, value_y, value_z
// out     | output    | out_valid/out_stall| pos_*, mom_*, energy, alive
// cfg     | input     | cfg_we             | cfg_index, cfg_data
// An item without a tick shows its result once the energy is ready: the
// energy needs four serial multiplies and a 32-step square root.
// A tick with nonzero energy adds three passes, each a 64-step restoring
// division, and then computes the energy again before its result.
// Reset (arst_n low) clears the state, sets alive to one and
// step_length to 32'h0001_0000.
// The output register holds a result under stall; no new item is taken
// until it is delivered.
module relativistic_particle_push #(
	parameter int unsigned COORD_WIDTH = rpp_pkg::COORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] mom_x,
	output logic signed [31:0] mom_y,
	output logic signed [31:0] mom_z,
	output logic [31:0]        energy,
	output logic               alive,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);
	import rpp_pkg::*;

	localparam int unsigned CW = COORD_WIDTH;
	localparam logic signed [CW:0] PMAX = {2'b00, {(CW-1){1'b1}}};
	localparam logic signed [CW:0] PMIN = {2'b11, {(CW-1){1'b0}}};
	// The position update is wide enough for any step and any position.
	localparam int unsigned SW = ((CW > 32) ? CW : 32) + 2;
	localparam logic signed [SW-1:0] PMAX_W = SW'(PMAX);
	localparam logic signed [SW-1:0] PMIN_W = SW'(PMIN);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_APPLY  = 9'b000000010,
		ST_SQ     = 9'b000000100,
		ST_SQRT   = 9'b000001000,
		ST_DIVSET = 9'b000010000,
		ST_DIV    = 9'b000100000,
		ST_UPD    = 9'b001000000,
		ST_OUT    = 9'b010000000,
		ST_WAIT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [31:0] mass_q, step_q;
	logic signed [CW-1:0] pos_q [3];
	logic [31:0] mom_q [3];
	logic alive_q;
	logic [2:0] func_q;
	logic [31:0] val_q [3];
	logic tick_q;
	logic [1:0] idx_q;
	logic [6:0] cnt_q;
	logic [64:0] sum_q;
	logic [63:0] rad_q, rem_q, root_q;
	logic [63:0] num_q, quo_q, drem_q;
	logic [31:0] e_q;
	logic [63:0] prod_q;

	// Shared multiplier operands.
	logic [31:0] ma, mb;
	always_comb begin
		ma = mass_q;
		mb = mass_q;
		if (state_q == ST_DIVSET) begin
			ma = mag32(mom_q[idx_q]);
			mb = step_q;
		end else if (idx_q != 2'd3) begin
			ma = mag32(mom_q[idx_q]);
			mb = ma;
		end
	end

	logic [65:0] sqt;
	logic [64:0] dtry;
	logic [63:0] rsh;
	logic [64:0] sacc;
	always_comb begin
		rsh  = {rem_q[61:0], rad_q[63:62]};
		sqt  = {2'b0, rsh} - {2'b0, root_q[61:0], 2'b01};
		dtry = {drem_q, num_q[63]} - {33'd0, e_q};
		sacc = sum_q + {1'b0, prod_q};
	end

	logic signed [SW-1:0] nsum;
	logic signed [SW-1:0] dsat;
	always_comb begin
		dsat = signed'({1'b0, quo_q[SW-2:0]});
		if (mom_q[idx_q][31]) dsat = -dsat;
		nsum = SW'(pos_q[idx_q]) + dsat;
	end

	function automatic logic signed [CW-1:0] satv(input logic [31:0] v);
		logic signed [63:0] w;
		w = 64'(signed'(v));
		if (w > 64'(PMAX)) satv = PMAX[CW-1:0];
		else if (w < 64'(PMIN)) satv = PMIN[CW-1:0];
		else satv = w[CW-1:0];
	endfunction

	function automatic logic [31:0] out32(input logic signed [CW-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > 64'sh7FFF_FFFF) out32 = 32'h7FFF_FFFF;
		else if (w < -64'sh8000_0000) out32 = 32'h8000_0000;
		else out32 = w[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mass_q  <= '0;
			step_q  <= STEP_LENGTH_RST;
			alive_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				mom_q[i] <= '0;
			end
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_REST_MASS) mass_q <= cfg_data;
				else step_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						val_q[0] <= value_x;
						val_q[1] <= value_y;
						val_q[2] <= value_z;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					tick_q <= (func_t'(func_q) == FN_TICK);
					case (func_t'(func_q))
						FN_TICK: ;
						FN_ABSORB, FN_FISSION: alive_q <= 1'b0;
						FN_SCATTER: begin
							mom_q[0] <= 32'(signed'(mom_q[0]) / 2);
							mom_q[1] <= 32'(signed'(mom_q[1]) / 2);
						end
						FN_LOADPOS, FN_MOVETO:
							for (int i = 0; i < 3; i++) pos_q[i] <= satv(val_q[i]);
						FN_LOADMOM:
							for (int i = 0; i < 3; i++) mom_q[i] <= val_q[i];
						default: ;
					endcase
					idx_q <= 2'd3;
					cnt_q <= '0;
					sum_q <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					// Step 0 multiplies, step 1 accumulates with saturation.
					if (!cnt_q[0]) begin
						prod_q <= ma * mb;
						cnt_q  <= cnt_q + 7'd1;
					end else begin
						sum_q <= (sacc > {1'b0, {64{1'b1}}}) ? {1'b0, {64{1'b1}}} : sacc;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							rad_q  <= (sacc > {1'b0, {64{1'b1}}}) ? {64{1'b1}} : sacc[63:0];
							rem_q  <= '0;
							root_q <= '0;
							cnt_q  <= '0;
							state_q <= ST_SQRT;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				ST_SQRT: begin
					rad_q <= {rad_q[61:0], 2'b00};
					if (!sqt[65]) begin
						rem_q  <= sqt[63:0];
						root_q <= {root_q[62:0], 1'b1};
					end else begin
						rem_q  <= rsh;
						root_q <= {root_q[62:0], 1'b0};
					end
					if (cnt_q == 7'd31) begin
						cnt_q <= '0;
						idx_q <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_OUT: begin
					e_q <= root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];
					if (tick_q && root_q != 64'd0) begin
						tick_q <= 1'b0;
						state_q <= ST_DIVSET;
					end else begin
						state_q <= ST_WAIT;
						out_valid <= 1'b1;
						pos_x <= out32(pos_q[0]);
						pos_y <= out32(pos_q[1]);
						pos_z <= out32(pos_q[2]);
						mom_x <= mom_q[0];
						mom_y <= mom_q[1];
						mom_z <= mom_q[2];
						energy <= root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];
						alive <= alive_q;
					end
				end
				ST_DIVSET: begin
					num_q  <= ma * mb;
					drem_q <= '0;
					cnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					num_q <= {num_q[62:0], 1'b0};
					if (!dtry[64]) begin
						drem_q <= dtry[63:0];
						quo_q  <= {quo_q[62:0], 1'b1};
					end else begin
						drem_q <= {drem_q[62:0], num_q[63]};
						quo_q  <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (nsum > PMAX_W) pos_q[idx_q] <= PMAX[CW-1:0];
					else if (nsum < PMIN_W) pos_q[idx_q] <= PMIN[CW-1:0];
					else pos_q[idx_q] <= nsum[CW-1:0];
					if (idx_q == 2'd2) begin
						idx_q <= 2'd3;
						cnt_q <= '0;
						sum_q <= '0;
						state_q <= ST_SQ;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= ST_DIVSET;
					end
				end
				ST_WAIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == (state_q == ST_WAIT)) else $error("valid out of step");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (idx_q != 2'd3)) else $error("bad axis");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

import rpp_pkg::*;

typedef struct {
	logic signed [31:0] pos [3];
	logic signed [31:0] mom [3];
	logic [31:0]        energy;
	logic               alive;
} particle_state_t;

class particle_scoreboard;
	longint            pos [3];
	int                mom [3];
	bit                alive_flag;
	bit [31:0]         rest_mass;
	bit [31:0]         step_length;
	particle_state_t   pending [$];
	int                errors;
	int                checked;

	function new();
		for (int i = 0; i < 3; i++) begin
			pos[i] = 0;
			mom[i] = 0;
		end
		alive_flag  = 1'b1;
		rest_mass   = 32'd0;
		step_length = STEP_LENGTH_RST;
		errors      = 0;
		checked     = 0;
	endfunction

	function void write_reg(logic index, bit [31:0] data);
		if (index == REG_REST_MASS)
			rest_mass = data;
		else
			step_length = data;
	endfunction

	function bit [63:0] magnitude(int v);
		longint lv;
		lv = v;
		return (lv < 0) ? 64'(-lv) : 64'(lv);
	endfunction

	// Floored integer square root, one result bit per pass.
	function bit [63:0] root64(bit [63:0] n);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function bit [63:0] total_energy();
		bit [63:0] sum;
		bit [63:0] sq;
		bit [63:0] s;
		sum = 64'(rest_mass) * 64'(rest_mass);
		for (int i = 0; i < 3; i++) begin
			sq = magnitude(mom[i]) * magnitude(mom[i]);
			s = sum + sq;
			sum = (s < sum) ? '1 : s;
		end
		return root64(sum);
	endfunction

	function longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function void note_item(func_t f, int vx, int vy, int vz);
		bit [63:0]       e;
		bit [63:0]       q;
		longint          d;
		int              vals [3];
		particle_state_t r;
		vals[0] = vx;
		vals[1] = vy;
		vals[2] = vz;
		case (f)
			FN_TICK: begin
				e = total_energy();
				// With no energy there is no momentum, so the particle stays put.
				if (e != 0) begin
					for (int i = 0; i < 3; i++) begin
						q = (magnitude(mom[i]) * 64'(step_length)) / e;
						d = longint'(q);
						if (mom[i] < 0)
							d = -d;
						pos[i] = clamp32(pos[i] + d);
					end
				end
			end
			FN_ABSORB, FN_FISSION: alive_flag = 1'b0;
			FN_SCATTER: begin
				mom[0] = mom[0] / 2;
				mom[1] = mom[1] / 2;
			end
			FN_LOADPOS, FN_MOVETO: begin
				for (int i = 0; i < 3; i++)
					pos[i] = clamp32(vals[i]);
			end
			FN_LOADMOM: begin
				for (int i = 0; i < 3; i++)
					mom[i] = vals[i];
			end
			default: ;
		endcase
		e = total_energy();
		for (int i = 0; i < 3; i++) begin
			r.pos[i] = 32'(clamp32(pos[i]));
			r.mom[i] = mom[i];
		end
		r.energy = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
		r.alive = alive_flag;
		pending.push_back(r);
	endfunction

	function void mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
		errors++;
	endfunction

	function void check_result(particle_state_t act);
		particle_state_t exp_r;
		string names [3];
		names = '{"x", "y", "z"};
		if (pending.size() == 0) begin
			$display("%0t: result arrived with nothing pending", $time);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		checked++;
		for (int i = 0; i < 3; i++) begin
			if (act.pos[i] !== exp_r.pos[i])
				mismatch({"pos_", names[i]}, exp_r.pos[i], act.pos[i]);
			if (act.mom[i] !== exp_r.mom[i])
				mismatch({"mom_", names[i]}, exp_r.mom[i], act.mom[i]);
		end
		if (act.energy !== exp_r.energy)
			mismatch("energy", exp_r.energy, act.energy);
		if (act.alive !== exp_r.alive)
			mismatch("alive", 32'(exp_r.alive), 32'(act.alive));
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 300;
	localparam int LONG_HOLD  = 400;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	func_t              func;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] mom_x;
	logic signed [31:0] mom_y;
	logic signed [31:0] mom_z;
	logic [31:0]        energy;
	logic               alive;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_data;

	particle_scoreboard sb;
	bit                 hold_req;
	bit                 gaps_on;
	int                 burst_left;
	int                 sent;
	int                 ticks_sent;
	int                 cfg_writes;

	relativistic_particle_push dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FN_NOP;
		value_x   = '0;
		value_y   = '0;
		value_z   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_REST_MASS;
		cfg_data  = '0;
		hold_req  = 1'b0;
		sb        = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: stall pattern is picked at random from four modes, with a long hold on request.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(50, 400);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 8);
					default: out_stall <= (($urandom_range(0, 15) == 0) ? ~out_stall : out_stall);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		particle_state_t act;
		if (arst_n && out_valid && !out_stall) begin
			act.pos[0] = pos_x;
			act.pos[1] = pos_y;
			act.pos[2] = pos_z;
			act.mom[0] = mom_x;
			act.mom[1] = mom_y;
			act.mom[2] = mom_z;
			act.energy = energy;
			act.alive  = alive;
			sb.check_result(act);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_op(func_t f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		value_x  <= x;
		value_y  <= y;
		value_z  <= z;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_item(f, x, y, z);
		sent++;
		if (f == FN_TICK)
			ticks_sent++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 25)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		// Let the block settle after the last check before going on.
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(index, data);
		cfg_writes++;
	endtask

	function automatic logic [31:0] pick_value(bit narrow);
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return narrow ? 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000)
				: $urandom;
		endcase
	endfunction

	task automatic random_op(bit narrow);
		func_t f;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 40)
			f = FN_TICK;
		else if (r < 55)
			f = FN_LOADMOM;
		else if (r < 63)
			f = FN_LOADPOS;
		else if (r < 70)
			f = FN_MOVETO;
		else if (r < 82)
			f = FN_SCATTER;
		else if (r < 86)
			f = FN_ABSORB;
		else if (r < 90)
			f = FN_FISSION;
		else
			f = FN_NOP;
		send_op(f, pick_value(narrow), pick_value(narrow), pick_value(narrow));
	endtask

	initial begin
		logic [31:0] masses [5];
		logic [31:0] steps [5];
		@(posedge arst_n);
		sent = 0;
		ticks_sent = 0;
		cfg_writes = 0;
		burst_left = 0;
		gaps_on = 1'b0;

		// Directed: zero-energy tick, plain motion, saturation, scatter on odd
		// negatives, every opcode, and a dead particle that keeps moving.
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_LOADMOM, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		send_op(FN_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(FN_LOADPOS, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(FN_LOADMOM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_LOADMOM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_LOADMOM, 32'hFFFF_FFFD, 32'h0000_0007, 32'h8000_0000);
		send_op(FN_SCATTER, 32'h0, 32'h0, 32'h0);
		send_op(FN_SCATTER, 32'h0, 32'h0, 32'h0);
		send_op(FN_MOVETO, 32'h0, 32'h0, 32'h0);
		send_op(FN_NOP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_ABSORB, 32'h0, 32'h0, 32'h0);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		send_op(FN_FISSION, 32'h0, 32'h0, 32'h0);
		send_op(FN_LOADMOM, 32'h0000_1234, 32'hFFFF_0000, 32'h0);
		send_op(FN_TICK, 32'h0, 32'h0, 32'h0);
		drain();

		masses = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0};
		steps  = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
		masses[3] = $urandom;
		steps[3]  = $urandom;
		steps[4]  = $urandom_range(1, 32'h0010_0000);
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_REST_MASS, masses[ph]);
			write_reg(REG_STEP_LENGTH, steps[ph]);
			gaps_on = (ph != 1);
			for (int n = 0; n < 176; n++) begin
				if (ph == 2 && n == 90)
					drain();
				if (ph == 3 && n == 60)
					hold_req = 1'b1;
				random_op(ph != 1);
			end
			drain();
		end

		$display("Sent %0d operations (%0d ticks) over %0d register writes; %0d results checked.",
			sent, ticks_sent, cfg_writes, sb.checked);
		sb.errors += sb.pending.size();
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d errors", sb.errors);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
